### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/pidaw_pkg.sv
`default_nettype none

package pidaw_pkg;

    localparam int DATA_W      = 32;
    localparam int DT_W        = 16;
    localparam int FUNC_W      = 2;
    localparam int INTEG_W     = 40;
    localparam int RAW_W       = 42;
    localparam int OPND_W      = 33;
    localparam int PROD_W      = 66;
    localparam int ACC_W       = 76;
    localparam int DIV_NUM_W   = 33;
    localparam int DIV_Q_W     = 49;
    localparam int DIV_STEPS   = 49;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 120;

    localparam logic [FUNC_W-1:0] FUNC_NUMERIC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUPPLIED = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_GAIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX    = 3'd5;

    // saturate an accumulator value to the integral width
    function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [ACC_W-1:0] v);
        logic signed [INTEG_W-1:0] r;
        if (v[ACC_W-1:INTEG_W-1] == {(ACC_W-INTEG_W+1){v[ACC_W-1]}})
            r = v[INTEG_W-1:0];
        else if (v[ACC_W-1])
            r = {1'b1, {(INTEG_W-1){1'b0}}};
        else
            r = {1'b0, {(INTEG_W-1){1'b1}}};
        return r;
    endfunction

    // saturate an accumulator value to the raw sum width
    function automatic logic signed [RAW_W-1:0] sat_raw(input logic signed [ACC_W-1:0] v);
        logic signed [RAW_W-1:0] r;
        if (v[ACC_W-1:RAW_W-1] == {(ACC_W-RAW_W+1){v[ACC_W-1]}})
            r = v[RAW_W-1:0];
        else if (v[ACC_W-1])
            r = {1'b1, {(RAW_W-1){1'b0}}};
        else
            r = {1'b0, {(RAW_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/pid_antiwindup_controller.sv
// Fixed-point PID controller with feed-forward, output clamp and anti-windup. One item is
// taken at a time: s_tready is high only while the sequencer is idle, and a finished result
// waits in the output register while the next item is already taken. All products go through
// one shared 33x33 multiplier and one 76-bit adder, one step per cycle unless waiting on the
// divider or the output. When the clamp acts the integral is discharged by a split multiply;
// a clear or an unused selector goes straight to the output step. A numeric derivative with a
// nonzero step time runs a bit-serial divider of 49 steps plus a saturation step in parallel
// with the first products, and the derivative term waits for it. The user must write gains and
// limits over the cfg port only while no item is in flight; the block does not enforce this.
`default_nettype none
`include "assert_macros.svh"

module pid_antiwindup_controller (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // err, err_rate, ff_ref, step_time
    input  wire logic [pidaw_pkg::IN_TDATA_W-1:0]       s_tdata,
    // func
    input  wire logic [pidaw_pkg::FUNC_W-1:0]           s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // drive, drive_raw, clamped, integ_value, zero_step, zero fill
    output logic [pidaw_pkg::OUT_TDATA_W-1:0]           m_tdata,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [pidaw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [pidaw_pkg::DATA_W-1:0]           cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_M_EDT  = 4'd1;
    localparam logic [3:0] ST_M_KIX  = 4'd2;
    localparam logic [3:0] ST_A_INT  = 4'd3;
    localparam logic [3:0] ST_A_P    = 4'd4;
    localparam logic [3:0] ST_A_FF   = 4'd5;
    localparam logic [3:0] ST_WAIT_D = 4'd6;
    localparam logic [3:0] ST_A_D    = 4'd7;
    localparam logic [3:0] ST_RAW    = 4'd8;
    localparam logic [3:0] ST_CLAMP  = 4'd9;
    localparam logic [3:0] ST_DIFF   = 4'd10;
    localparam logic [3:0] ST_M_LO   = 4'd11;
    localparam logic [3:0] ST_M_HI   = 4'd12;
    localparam logic [3:0] ST_A_HI   = 4'd13;
    localparam logic [3:0] ST_A_AW   = 4'd14;
    localparam logic [3:0] ST_FIN    = 4'd15;

    localparam int DW = pidaw_pkg::DATA_W;
    localparam int IW = pidaw_pkg::INTEG_W;
    localparam int RW = pidaw_pkg::RAW_W;
    localparam int AW = pidaw_pkg::ACC_W;
    localparam int PW = pidaw_pkg::PROD_W;
    localparam int OW = pidaw_pkg::OPND_W;

    logic [3:0]                  state_reg, state_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [pidaw_pkg::OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic signed [DW-1:0]        prop_gain_reg, integ_gain_reg, deriv_gain_reg, ff_gain_reg;
    logic signed [DW-1:0]        out_min_reg, out_max_reg;
    logic signed [DW-1:0]        last_error_reg, last_error_next;
    logic signed [IW-1:0]        integral_reg, integral_next;

    logic [pidaw_pkg::FUNC_W-1:0] func_reg, func_next;
    logic signed [DW-1:0]        err_reg, err_next;
    logic signed [DW-1:0]        rate_reg, rate_next;
    logic signed [DW-1:0]        ffr_reg, ffr_next;
    logic [pidaw_pkg::DT_W-1:0]  dt_reg, dt_next;
    logic                        zstep_reg, zstep_next;
    logic                        null_reg, null_next;
    logic signed [RW-1:0]        raw_reg, raw_next;
    logic signed [DW-1:0]        drive_reg, drive_next;
    logic                        clamp_reg, clamp_next;
    logic signed [AW-1:0]        acc_reg, acc_next;
    logic signed [PW-1:0]        prod_reg, prod_next;

    logic signed [OW-1:0]        mul_a, mul_b;
    logic signed [AW-1:0]        add_x, add_y, sum;
    logic                        add_cin;
    logic signed [AW-1:0]        term;
    logic signed [DW-1:0]        deriv;
    logic signed [RW-1:0]        max_ext, min_ext, dsel;

    logic                        in_xfer;
    logic                        out_free;
    logic                        div_start;
    logic                        div_busy;
    logic signed [pidaw_pkg::DIV_NUM_W-1:0] div_num;
    logic signed [DW-1:0]        div_quo;
    logic                        out_at_limit;

    logic [pidaw_pkg::FUNC_W-1:0] in_func;
    logic signed [DW-1:0]        in_err, in_rate, in_ffr;
    logic [pidaw_pkg::DT_W-1:0]  in_dt;

    assign in_func = s_tuser;
    assign in_err  = s_tdata[31:0];
    assign in_rate = s_tdata[63:32];
    assign in_ffr  = s_tdata[95:64];
    assign in_dt   = s_tdata[111:96];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign div_num   = {in_err[DW-1], in_err} - {last_error_reg[DW-1], last_error_reg};
    assign div_start = in_xfer && (in_func == pidaw_pkg::FUNC_NUMERIC) && (in_dt != '0);

    pidaw_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (in_dt),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    // shared multiplier and adder
    assign prod_next = mul_a * mul_b;
    assign sum       = add_x + add_y + {{(AW-1){1'b0}}, add_cin};
    assign term      = {{(AW-48){prod_reg[63]}}, prod_reg[63:16]};
    assign max_ext   = {{(RW-DW){out_max_reg[DW-1]}}, out_max_reg};
    assign min_ext   = {{(RW-DW){out_min_reg[DW-1]}}, out_min_reg};

    always_comb
    begin
        if (func_reg == pidaw_pkg::FUNC_SUPPLIED)
            deriv = rate_reg;
        else if (zstep_reg)
            deriv = '0;
        else
            deriv = div_quo;
    end

    always_comb
    begin
        dsel = (raw_reg < max_ext) ? raw_reg : max_ext;
        if (dsel < min_ext)
            dsel = min_ext;
    end

    always_comb
    begin
        state_next      = state_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        last_error_next = last_error_reg;
        integral_next   = integral_reg;
        func_next       = func_reg;
        err_next        = err_reg;
        rate_next       = rate_reg;
        ffr_next        = ffr_reg;
        dt_next         = dt_reg;
        zstep_next      = zstep_reg;
        null_next       = null_reg;
        raw_next        = raw_reg;
        drive_next      = drive_reg;
        clamp_next      = clamp_reg;
        acc_next        = acc_reg;
        mul_a           = '0;
        mul_b           = '0;
        add_x           = '0;
        add_y           = '0;
        add_cin         = 1'b0;

        if (m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    func_next  = in_func;
                    err_next   = in_err;
                    rate_next  = in_rate;
                    ffr_next   = in_ffr;
                    dt_next    = in_dt;
                    zstep_next = (in_func == pidaw_pkg::FUNC_NUMERIC) && (in_dt == '0);
                    null_next  = (in_func != pidaw_pkg::FUNC_NUMERIC) &&
                                 (in_func != pidaw_pkg::FUNC_SUPPLIED);
                    if (in_func == pidaw_pkg::FUNC_CLEAR)
                    begin
                        last_error_next = '0;
                        integral_next   = '0;
                    end
                    if ((in_func == pidaw_pkg::FUNC_NUMERIC) ||
                        (in_func == pidaw_pkg::FUNC_SUPPLIED))
                        state_next = ST_M_EDT;
                    else
                        state_next = ST_FIN;
                end
            end
            ST_M_EDT:
            begin
                mul_a      = {err_reg[DW-1], err_reg};
                mul_b      = {{(OW-pidaw_pkg::DT_W){1'b0}}, dt_reg};
                state_next = ST_M_KIX;
            end
            ST_M_KIX:
            begin
                mul_a      = {integ_gain_reg[DW-1], integ_gain_reg};
                mul_b      = {prod_reg[47], prod_reg[47:16]};
                state_next = ST_A_INT;
            end
            ST_A_INT:
            begin
                mul_a         = {prop_gain_reg[DW-1], prop_gain_reg};
                mul_b         = {err_reg[DW-1], err_reg};
                add_x         = {{(AW-IW){integral_reg[IW-1]}}, integral_reg};
                add_y         = term;
                integral_next = pidaw_pkg::sat_integ(sum);
                state_next    = ST_A_P;
            end
            ST_A_P:
            begin
                mul_a      = {ff_gain_reg[DW-1], ff_gain_reg};
                mul_b      = {ffr_reg[DW-1], ffr_reg};
                add_x      = {{(AW-IW){integral_reg[IW-1]}}, integral_reg};
                add_y      = term;
                acc_next   = sum;
                state_next = ST_A_FF;
            end
            ST_A_FF:
            begin
                add_x      = acc_reg;
                add_y      = term;
                acc_next   = sum;
                state_next = ST_WAIT_D;
            end
            ST_WAIT_D:
            begin
                mul_a = {deriv_gain_reg[DW-1], deriv_gain_reg};
                mul_b = {deriv[DW-1], deriv};
                if (!div_busy)
                    state_next = ST_A_D;
            end
            ST_A_D:
            begin
                add_x      = acc_reg;
                add_y      = term;
                acc_next   = sum;
                state_next = ST_RAW;
            end
            ST_RAW:
            begin
                raw_next   = pidaw_pkg::sat_raw(acc_reg);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                drive_next = dsel[DW-1:0];
                clamp_next = (raw_reg > max_ext) || (raw_reg < min_ext);
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                // drive minus raw, kept in the accumulator for the split multiply
                add_x    = {{(AW-DW){drive_reg[DW-1]}}, drive_reg};
                add_y    = ~{{(AW-RW){raw_reg[RW-1]}}, raw_reg};
                add_cin  = 1'b1;
                acc_next = sum;
                if (clamp_reg)
                    state_next = ST_M_LO;
                else
                    state_next = ST_FIN;
            end
            ST_M_LO:
            begin
                mul_a      = {integ_gain_reg[DW-1], integ_gain_reg};
                mul_b      = {1'b0, acc_reg[31:0]};
                state_next = ST_M_HI;
            end
            ST_M_HI:
            begin
                mul_a      = {integ_gain_reg[DW-1], integ_gain_reg};
                mul_b      = {{(OW-11){acc_reg[42]}}, acc_reg[42:32]};
                add_x      = {{(AW-PW){prod_reg[PW-1]}}, prod_reg};
                acc_next   = sum;
                state_next = ST_A_HI;
            end
            ST_A_HI:
            begin
                add_x      = acc_reg;
                add_y      = {prod_reg[AW-33:0], 32'b0};
                acc_next   = sum;
                state_next = ST_A_AW;
            end
            ST_A_AW:
            begin
                add_x         = {{(AW-IW){integral_reg[IW-1]}}, integral_reg};
                add_y         = {{16{acc_reg[AW-1]}}, acc_reg[AW-1:16]};
                integral_next = pidaw_pkg::sat_integ(sum);
                state_next    = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    if (null_reg)
                        m_tdata_next = '0;
                    else
                    begin
                        m_tdata_next    = {4'b0, zstep_reg, integral_reg, clamp_reg,
                                           raw_reg, drive_reg};
                        last_error_next = err_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            m_tvalid_reg   <= 1'b0;
            last_error_reg <= '0;
            integral_reg   <= '0;
            prop_gain_reg  <= '0;
            integ_gain_reg <= '0;
            deriv_gain_reg <= '0;
            ff_gain_reg    <= '0;
            out_min_reg    <= {1'b1, {(DW-1){1'b0}}};
            out_max_reg    <= {1'b0, {(DW-1){1'b1}}};
        end
        else
        begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            last_error_reg <= last_error_next;
            integral_reg   <= integral_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    pidaw_pkg::CFG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                    pidaw_pkg::CFG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                    pidaw_pkg::CFG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                    pidaw_pkg::CFG_FF_GAIN:    ff_gain_reg    <= cfg_data;
                    pidaw_pkg::CFG_OUT_MIN:    out_min_reg    <= cfg_data;
                    pidaw_pkg::CFG_OUT_MAX:    out_max_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        func_reg    <= func_next;
        err_reg     <= err_next;
        rate_reg    <= rate_next;
        ffr_reg     <= ffr_next;
        dt_reg      <= dt_next;
        zstep_reg   <= zstep_next;
        null_reg    <= null_next;
        raw_reg     <= raw_next;
        drive_reg   <= drive_next;
        clamp_reg   <= clamp_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
    end

    assign out_at_limit = (m_tdata[31:0] == out_min_reg) || (m_tdata[31:0] == out_max_reg);

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `ASSERT_IMPLIES(a_deriv_settled, clk, rst_n, state_reg == ST_A_D, !div_busy)
    `ASSERT_IMPLIES(a_clamp_at_limit, clk, rst_n, m_tvalid && m_tdata[74], out_at_limit)

endmodule

`default_nettype wire

### rtl/core/pidaw_div.sv
`default_nettype none

module pidaw_div (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    start,
    input  wire logic signed [pidaw_pkg::DIV_NUM_W-1:0]  num,
    input  wire logic        [pidaw_pkg::DT_W-1:0]       den,
    output logic                                         busy,
    output logic signed      [pidaw_pkg::DATA_W-1:0]     quo
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_SAT  = 2'd2;
    localparam int CNT_W = $clog2(pidaw_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pidaw_pkg::DIV_STEPS - 1);

    logic [1:0]                          state_reg, state_next;
    logic [CNT_W-1:0]                    cnt_reg, cnt_next;
    logic                                neg_reg, neg_next;
    logic [pidaw_pkg::DT_W-1:0]          rem_reg, rem_next;
    logic [pidaw_pkg::DT_W-1:0]          den_reg, den_next;
    logic [pidaw_pkg::DIV_Q_W-1:0]       dq_reg, dq_next;
    logic signed [pidaw_pkg::DATA_W-1:0] quo_reg, quo_next;

    logic [pidaw_pkg::DIV_NUM_W-1:0]     mag;
    logic [pidaw_pkg::DT_W:0]            shifted;
    logic [pidaw_pkg::DT_W:0]            trial;
    logic                                ge;
    logic                                big_pos;
    logic                                big_neg;

    assign busy = (state_reg != D_IDLE);
    assign quo  = quo_reg;

    always_comb
    begin
        mag     = num[pidaw_pkg::DIV_NUM_W-1] ? (~num + 1'b1) : num;
        shifted = {rem_reg, dq_reg[pidaw_pkg::DIV_Q_W-1]};
        ge      = (shifted >= {1'b0, den_reg});
        trial   = shifted - {1'b0, den_reg};
        // quotient beyond the signed 32-bit range
        big_pos = |dq_reg[pidaw_pkg::DIV_Q_W-1:31];
        big_neg = (|dq_reg[pidaw_pkg::DIV_Q_W-1:32]) || (dq_reg[31] && (|dq_reg[30:0]));

        state_next = state_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        dq_next    = dq_reg;
        quo_next   = quo_reg;

        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    neg_next   = num[pidaw_pkg::DIV_NUM_W-1];
                    dq_next    = {mag, {pidaw_pkg::DT_W{1'b0}}};
                    rem_next   = '0;
                    den_next   = den;
                    cnt_next   = '0;
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = ge ? trial[pidaw_pkg::DT_W-1:0] : shifted[pidaw_pkg::DT_W-1:0];
                dq_next  = {dq_reg[pidaw_pkg::DIV_Q_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = D_SAT;
            end
            D_SAT:
            begin
                if (neg_reg)
                    quo_next = big_neg ? {1'b1, 31'b0} : -$signed(dq_reg[31:0]);
                else
                    quo_next = big_pos ? {1'b0, {31{1'b1}}} : $signed(dq_reg[31:0]);
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        dq_reg  <= dq_next;
        quo_reg <= quo_next;
    end

endmodule

`default_nettype wire

### sim/pid_antiwindup_controller_test.sv
`default_nettype none

module pid_antiwindup_controller_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pidaw_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_PHASES = 9;
    localparam int ITEMS_PER_PHASE = 150;

    typedef logic signed [127:0] wide_t;

    typedef enum
    {
        FLOW_FULL,
        FLOW_SRC_GAPS,
        FLOW_SINK_STALLS,
        FLOW_BOTH
    } flow_mode_t;

    typedef struct
    {
        logic [FUNC_W-1:0]          func;
        logic signed [DATA_W-1:0]   err;
        logic signed [DATA_W-1:0]   err_rate;
        logic signed [DATA_W-1:0]   ff_ref;
        logic [DT_W-1:0]            step_time;
    } ctrl_item_t;

    typedef struct
    {
        logic [DATA_W-1:0]  drive;
        logic [RAW_W-1:0]   drive_raw;
        logic               clamped;
        logic [INTEG_W-1:0] integ_value;
        logic               zero_step;
    } pid_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic [FUNC_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0] cfg_data = '0;

    // controller model state and registers
    logic signed [DATA_W-1:0] kp = '0;
    logic signed [DATA_W-1:0] ki = '0;
    logic signed [DATA_W-1:0] kd = '0;
    logic signed [DATA_W-1:0] kff = '0;
    logic signed [DATA_W-1:0] lim_lo = 32'sh8000_0000;
    logic signed [DATA_W-1:0] lim_hi = 32'sh7fff_ffff;
    logic signed [DATA_W-1:0] prev_err = '0;
    logic signed [INTEG_W-1:0] integ_acc = '0;

    ctrl_item_t ctrl_pending[$];
    ctrl_item_t cur_item;
    pid_result_t drive_expected[$];
    int unsigned items_issued = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatches = 0;
    flow_mode_t flow = FLOW_FULL;

    pid_antiwindup_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic wide_t clip(wide_t v, int unsigned w);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // one controller update; advances the model state
    function automatic pid_result_t pid_update(ctrl_item_t it);
        pid_result_t r;
        wide_t e;
        wide_t last;
        wide_t dt;
        wide_t deriv;
        wide_t integ;
        wide_t raw;
        wide_t drv;
        wide_t hi;
        wide_t lo;
        logic clamp;
        r = '{default: '0};
        if (it.func == FUNC_CLEAR || it.func == FUNC_UNUSED)
        begin
            if (it.func == FUNC_CLEAR)
            begin
                prev_err = '0;
                integ_acc = '0;
            end
            return r;
        end
        e = it.err;
        last = prev_err;
        dt = it.step_time;
        hi = lim_hi;
        lo = lim_lo;
        if (it.func == FUNC_NUMERIC)
        begin
            if (dt == 0)
            begin
                deriv = 0;
                r.zero_step = 1'b1;
            end
            else
                deriv = clip(((e - last) * 65536) / dt, DATA_W);
        end
        else
            deriv = it.err_rate;
        integ = integ_acc;
        integ = clip(integ + ((wide_t'(ki) * ((e * dt) >>> 16)) >>> 16), INTEG_W);
        raw = ((wide_t'(kp) * e) >>> 16) + ((wide_t'(kd) * deriv) >>> 16) + integ
            + ((wide_t'(kff) * wide_t'(it.ff_ref)) >>> 16);
        raw = clip(raw, RAW_W);
        drv = (raw < hi) ? raw : hi;
        if (drv < lo)
            drv = lo;
        clamp = (raw > hi) || (raw < lo);
        if (clamp)
            integ = clip(integ + ((wide_t'(ki) * (drv - raw)) >>> 16), INTEG_W);
        integ_acc = integ[INTEG_W-1:0];
        prev_err = it.err;
        r.drive = drv[DATA_W-1:0];
        r.drive_raw = raw[RAW_W-1:0];
        r.clamped = clamp;
        r.integ_value = integ[INTEG_W-1:0];
        return r;
    endfunction

    function automatic logic sender_idle();
        case (flow)
            FLOW_SRC_GAPS: return $urandom_range(99) < 72;
            FLOW_BOTH:     return $urandom_range(99) < 29;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic logic sink_stall();
        case (flow)
            FLOW_SINK_STALLS: return $urandom_range(99) < 72;
            FLOW_BOTH:        return $urandom_range(99) < 29;
            default:          return 1'b0;
        endcase
    endfunction

    always @(posedge clk)
    begin : feed_items
        logic taken;
        if (rst_n)
        begin
            taken = s_tvalid && s_tready;
            if (taken)
            begin
                drive_expected.push_back(pid_update(cur_item));
                items_accepted++;
            end
            if (!s_tvalid || taken)
            begin
                if (ctrl_pending.size() != 0 && !sender_idle())
                begin
                    cur_item = ctrl_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_item.step_time, cur_item.ff_ref, cur_item.err_rate,
                                cur_item.err};
                    s_tuser <= cur_item.func;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : watch_results
        pid_result_t got;
        pid_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.drive = m_tdata[31:0];
                got.drive_raw = m_tdata[73:32];
                got.clamped = m_tdata[74];
                got.integ_value = m_tdata[114:75];
                got.zero_step = m_tdata[115];
                if (drive_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
                end
                else
                begin
                    want = drive_expected.pop_front();
                    check_field("drive", 64'(want.drive), 64'(got.drive));
                    check_field("drive_raw", 64'(want.drive_raw), 64'(got.drive_raw));
                    check_field("clamped", 64'(want.clamped), 64'(got.clamped));
                    check_field("integ_value", 64'(want.integ_value), 64'(got.integ_value));
                    check_field("zero_step", 64'(want.zero_step), 64'(got.zero_step));
                end
            end
            m_tready <= !sink_stall();
        end
    end

    task automatic wait_drained();
        while (items_accepted != items_issued || drive_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_PROP_GAIN:  kp = val;
            CFG_INTEG_GAIN: ki = val;
            CFG_DERIV_GAIN: kd = val;
            CFG_FF_GAIN:    kff = val;
            CFG_OUT_MIN:    lim_lo = val;
            CFG_OUT_MAX:    lim_hi = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_tuning(logic signed [DATA_W-1:0] p, logic signed [DATA_W-1:0] i,
                              logic signed [DATA_W-1:0] d, logic signed [DATA_W-1:0] f,
                              logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi);
        write_reg(CFG_PROP_GAIN, p);
        write_reg(CFG_INTEG_GAIN, i);
        write_reg(CFG_DERIV_GAIN, d);
        write_reg(CFG_FF_GAIN, f);
        write_reg(CFG_OUT_MIN, lo);
        write_reg(CFG_OUT_MAX, hi);
    endtask

    task automatic queue_item(logic [FUNC_W-1:0] func, logic [31:0] err, logic [31:0] rate,
                              logic [31:0] ffr, logic [15:0] dt);
        ctrl_item_t it;
        it.func = func;
        it.err = err;
        it.err_rate = rate;
        it.ff_ref = ffr;
        it.step_time = dt;
        ctrl_pending.push_back(it);
        items_issued++;
    endtask

    // signed Q16.16 value in [-span, span]
    function automatic logic [31:0] near_zero_q16(int unsigned span);
        logic signed [31:0] v;
        v = $urandom_range(2 * span);
        return v - span;
    endfunction

    function automatic logic [31:0] pick_q16();
        case ($urandom_range(9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return near_zero_q16(32'd200 << 16);
            5:       return near_zero_q16(32'd2 << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(4))
            0:       return near_zero_q16(32'd4 << 16);
            1:       return near_zero_q16(32'h1000);
            2:       return $urandom;
            3:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return near_zero_q16(32'd64 << 16);
        endcase
    endfunction

    function automatic logic [15:0] pick_step();
        case ($urandom_range(11))
            0:       return 16'h0;
            1:       return 16'hffff;
            2, 3, 4: return 16'($urandom_range(1, 2000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random_item();
        int unsigned roll;
        logic [FUNC_W-1:0] func;
        roll = $urandom_range(99);
        if (roll < 45)
            func = FUNC_NUMERIC;
        else if (roll < 85)
            func = FUNC_SUPPLIED;
        else if (roll < 95)
            func = FUNC_CLEAR;
        else
            func = FUNC_UNUSED;
        queue_item(func, pick_q16(), pick_q16(), pick_q16(), pick_step());
    endtask

    initial
    begin : run_phases
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic signed [DATA_W-1:0] t;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: moderate limits, clamp both ways, zero step, clear, unused selector
        set_tuning(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h0001_0000,
                   -32'sd100 <<< 16, 32'sd100 <<< 16);
        queue_item(FUNC_NUMERIC, 32'h0001_0000, 32'h0, 32'h0, 16'h1000);
        queue_item(FUNC_NUMERIC, 32'h0002_0000, 32'h1234_5678, 32'h0, 16'h0);
        queue_item(FUNC_SUPPLIED, 32'hffff_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
        queue_item(FUNC_NUMERIC, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 16'h0001);
        queue_item(FUNC_NUMERIC, 32'h8000_0000, 32'hffff_ffff, 32'h0, 16'h0001);
        queue_item(FUNC_CLEAR, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        queue_item(FUNC_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'hffff);
        queue_item(FUNC_NUMERIC, 32'h0, 32'hffff_ffff, 32'h0, 16'hffff);
        queue_item(FUNC_SUPPLIED, 32'h0032_0000, 32'h0, 32'h003c_0000, 16'h8000);
        queue_item(FUNC_SUPPLIED, 32'hffb0_0000, 32'h0, 32'hffce_0000, 16'h8000);
        wait_drained();

        // saturating gains: integral and raw sum overflow
        set_tuning(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000, 32'h7fff_ffff);
        queue_item(FUNC_SUPPLIED, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff);
        queue_item(FUNC_SUPPLIED, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'hffff);
        queue_item(FUNC_SUPPLIED, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'hffff);
        queue_item(FUNC_NUMERIC, 32'h8000_0000, 32'h0, 32'h8000_0000, 16'hffff);
        queue_item(FUNC_CLEAR, 32'h0, 32'h0, 32'h0, 16'h0);
        wait_drained();

        // crossed limits
        set_tuning(32'h0001_0000, 32'h0, 32'h0000_0400, 32'h0001_0000,
                   32'sd10 <<< 16, -32'sd10 <<< 16);
        queue_item(FUNC_SUPPLIED, 32'h0, 32'h0, 32'h0, 16'h0100);
        queue_item(FUNC_NUMERIC, 32'h0014_0000, 32'h0, 32'h0, 16'h8000);
        queue_item(FUNC_SUPPLIED, 32'hffec_0000, 32'h0, 32'hfff0_0000, 16'h8000);
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            flow = flow_mode_t'(ph % 4);
            case (ph)
                0:
                begin
                    hi = $urandom_range(1, 500) << 16;
                    set_tuning(near_zero_q16(32'd4 << 16), near_zero_q16(32'd4 << 16),
                               near_zero_q16(32'h1000), near_zero_q16(32'd2 << 16), -hi, hi);
                end
                1:
                    set_tuning(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                               32'h8000_0000, 32'h7fff_ffff);
                2:
                begin
                    lo = $urandom_range(1, 100) << 16;
                    set_tuning(pick_gain(), pick_gain(), pick_gain(), pick_gain(), lo, -lo);
                end
                3:
                    set_tuning(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                               -32'sd1000 <<< 16, 32'sd1000 <<< 16);
                4:
                    set_tuning(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h7fff_ffff);
                default:
                begin
                    lo = pick_q16();
                    hi = pick_q16();
                    if (lo > hi && $urandom_range(3) != 0)
                    begin
                        t = lo;
                        lo = hi;
                        hi = t;
                    end
                    set_tuning(pick_gain(), pick_gain(), pick_gain(), pick_gain(), lo, hi);
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                queue_random_item();
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
